// ----- sv/auhd_pkg.sv -----
`timescale 1ns / 1ps

package auhd_pkg;

  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned FNUM_W       = 4;
  localparam int unsigned ERR_W        = 2;
  localparam int unsigned SIZE_W       = 13;
  localparam int unsigned FTOT_W       = 12;
  localparam int unsigned SIZE_SHIFT   = 3;
  localparam int unsigned FRAMES_SHIFT = 4;

  typedef logic [BYTE_W-1:0] byte_t;
  typedef logic [FNUM_W-1:0] fnum_t;
  typedef logic [ERR_W-1:0]  err_t;

  localparam err_t ERR_NONE   = 2'd0;
  localparam err_t ERR_TRUNC  = 2'd1;
  localparam err_t ERR_FRAMES = 2'd2;

  typedef enum logic [3:0] {
    PH_LEN_HI = 4'b0001,
    PH_LEN_LO = 4'b0010,
    PH_HDR    = 4'b0100,
    PH_PAY    = 4'b1000
  } phase_e;

endpackage

// ----- sv/auhd_if.sv -----
`timescale 1ns / 1ps

interface auhd_in_if;
  import auhd_pkg::*;

  logic  valid;
  logic  ready;
  byte_t packet_byte;
  logic  packet_end;

  modport source (output valid, output packet_byte, output packet_end, input ready);
  modport sink   (input valid, input packet_byte, input packet_end, output ready);
endinterface

interface auhd_out_if;
  import auhd_pkg::*;

  logic  valid;
  logic  ready;
  logic  has_byte;
  byte_t frame_byte;
  fnum_t frame_number;
  logic  frame_end;
  err_t  error_code;

  modport source (output valid, output has_byte, output frame_byte, output frame_number,
                  output frame_end, output error_code, input ready);
  modport sink   (input valid, input has_byte, input frame_byte, input frame_number,
                  input frame_end, input error_code, output ready);
endinterface

// ----- sv/au_header_depacketizer.sv -----
`timescale 1ns / 1ps

// AU-header depacketizer.
// in_i carries one packet byte per word, packet_end marks the last byte.
// The first two bytes give the AU-header length in bits (frame count = length/16),
// then two bytes per frame hold the 13-bit frame size. Payload bytes then leave on
// out_o tagged with frame number and a frame_end mark on the last byte of a frame.
// error_code 1 flags a packet that ends while bytes are still expected, 2 a frame
// count above MAX_FRAMES. Header bytes, zero-size frames and trailing bytes give
// no output word except for those errors.
// Throughput: one input word per cycle while out_o is not stalled. Nonzero frame sizes
// are written in order into a size memory; the next entry is prefetched through its
// registered read port when a frame starts, so frame changes cause no stall.
// Each output word is written into the output register when its byte is accepted.
// in_i is ready while the output register is empty or being emptied, so a stall on
// out_o holds the input; a held word is never overwritten.
// Reset clears all control state but head_q; head_q and the size memory need no
// clearing since every entry is written within a packet before it is used.
module au_header_depacketizer #(
  parameter int unsigned MAX_FRAMES = 16
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  auhd_in_if.sink    in_i,
  auhd_out_if.source out_o
);
  import auhd_pkg::*;

  localparam int unsigned AW = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int unsigned CW = $clog2(MAX_FRAMES + 1);
  localparam int unsigned HW = $clog2(2 * MAX_FRAMES + 1);

  typedef struct packed {
    logic [AW-1:0]     idx;
    logic [SIZE_W-1:0] size;
  } entry_t;

  // control state
  phase_e            phase_q, phase_d;
  byte_t             len_hi_q, len_hi_d;
  logic [CW-1:0]     ftot_q, ftot_d;
  logic [HW-1:0]     hb_q, hb_d;
  logic [CW-1:0]     nz_q, nz_d;
  logic [CW-1:0]     cur_k_q, cur_k_d;
  logic [AW-1:0]     cur_idx_q, cur_idx_d;
  logic [SIZE_W-1:0] left_q, left_d;
  logic              drop_q, drop_d;
  entry_t            head_q, head_d;

  // output register
  logic  out_valid_q, out_valid_d;
  logic  has_q, has_d;
  byte_t fb_q, fb_d;
  fnum_t fn_q, fn_d;
  logic  fe_q, fe_d;
  err_t  err_q, err_d;

  // size memory
  entry_t        mem [MAX_FRAMES];
  entry_t        rdata_q;
  entry_t        wentry;
  logic          we;
  logic [AW-1:0] waddr;
  logic          want_rd;
  logic [CW:0]   rd_k;
  logic          rd_en;
  logic [AW-1:0] raddr;

  logic              accept;
  logic              emit;
  logic [FTOT_W-1:0] total12;
  logic [SIZE_W-1:0] size13;
  logic [HW-1:0]     hb_next;
  logic [CW-1:0]     nz_new;
  logic [CW-1:0]     next_k;
  entry_t            first;

  assign in_i.ready = !out_valid_q || out_o.ready;
  assign accept     = in_i.valid && in_i.ready;

  assign total12 = FTOT_W'({len_hi_q, in_i.packet_byte} >> FRAMES_SHIFT);
  assign size13  = SIZE_W'({len_hi_q, in_i.packet_byte} >> SIZE_SHIFT);
  assign hb_next = hb_q + 1'b1;
  assign nz_new  = nz_q + CW'(we);
  assign next_k  = cur_k_q + 1'b1;
  assign first   = (we && (nz_q == '0)) ? wentry : head_q;

  always_comb begin
    phase_d   = phase_q;
    len_hi_d  = len_hi_q;
    ftot_d    = ftot_q;
    hb_d      = hb_q;
    nz_d      = nz_q;
    cur_k_d   = cur_k_q;
    cur_idx_d = cur_idx_q;
    left_d    = left_q;
    drop_d    = drop_q;
    head_d    = head_q;
    we        = 1'b0;
    waddr     = AW'(nz_q);
    wentry    = '{idx: AW'(hb_q >> 1), size: size13};
    want_rd   = 1'b0;
    rd_k      = '0;
    emit      = 1'b0;
    has_d     = 1'b0;
    fb_d      = '0;
    fn_d      = '0;
    fe_d      = 1'b0;
    err_d     = ERR_NONE;

    if (accept && !drop_q) begin
      unique case (phase_q)
        PH_LEN_HI: begin
          len_hi_d = in_i.packet_byte;
          phase_d  = PH_LEN_LO;
        end
        PH_LEN_LO: begin
          hb_d = '0;
          nz_d = '0;
          if (total12 > FTOT_W'(MAX_FRAMES)) begin
            err_d  = ERR_FRAMES;
            emit   = 1'b1;
            drop_d = 1'b1;
          end else if (total12 == '0) begin
            drop_d = 1'b1;
          end else begin
            ftot_d  = CW'(total12);
            phase_d = PH_HDR;
          end
        end
        PH_HDR: begin
          if (!hb_q[0]) begin
            len_hi_d = in_i.packet_byte;
          end else if (size13 != '0) begin
            // only nonzero frames are stored, packed in order
            we   = 1'b1;
            nz_d = nz_new;
            if (nz_q == '0) head_d = wentry;
          end
          hb_d = hb_next;
          if ((HW + 1)'(hb_next) >= (HW + 1)'({ftot_q, 1'b0})) begin
            if (nz_new == '0) begin
              drop_d = 1'b1;
            end else begin
              phase_d   = PH_PAY;
              cur_k_d   = '0;
              cur_idx_d = first.idx;
              left_d    = first.size;
              want_rd   = 1'b1;
              rd_k      = (CW + 1)'(1);
            end
          end
        end
        PH_PAY: begin
          emit   = 1'b1;
          has_d  = 1'b1;
          fb_d   = in_i.packet_byte;
          fn_d   = FNUM_W'(cur_idx_q);
          left_d = left_q - 1'b1;
          if (left_q == SIZE_W'(1)) begin
            fe_d = 1'b1;
            if (next_k < nz_q) begin
              cur_k_d   = next_k;
              cur_idx_d = rdata_q.idx;
              left_d    = rdata_q.size;
              want_rd   = 1'b1;
              rd_k      = (CW + 1)'(next_k) + 1'b1;
            end else begin
              drop_d = 1'b1;
            end
          end
        end
        default: phase_d = PH_LEN_HI;
      endcase
    end

    if (accept && in_i.packet_end) begin
      if (!drop_d) begin
        err_d = ERR_TRUNC;
        emit  = 1'b1;
      end
      phase_d   = PH_LEN_HI;
      len_hi_d  = '0;
      ftot_d    = '0;
      hb_d      = '0;
      nz_d      = '0;
      cur_k_d   = '0;
      cur_idx_d = '0;
      left_d    = '0;
      drop_d    = 1'b0;
    end

    out_valid_d = emit ? 1'b1 : (out_valid_q && !out_o.ready);
  end

  assign rd_en = accept && want_rd && (rd_k < (CW + 1)'(MAX_FRAMES));
  assign raddr = AW'(rd_k);

  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= wentry;
    if (rd_en) begin
      if (we && (waddr == raddr)) rdata_q <= wentry;
      else                         rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_LEN_HI;
      len_hi_q    <= '0;
      ftot_q      <= '0;
      hb_q        <= '0;
      nz_q        <= '0;
      cur_k_q     <= '0;
      cur_idx_q   <= '0;
      left_q      <= '0;
      drop_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      phase_q     <= phase_d;
      len_hi_q    <= len_hi_d;
      ftot_q      <= ftot_d;
      hb_q        <= hb_d;
      nz_q        <= nz_d;
      cur_k_q     <= cur_k_d;
      cur_idx_q   <= cur_idx_d;
      left_q      <= left_d;
      drop_q      <= drop_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    if (emit) begin
      has_q <= has_d;
      fb_q  <= fb_d;
      fn_q  <= fn_d;
      fe_q  <= fe_d;
      err_q <= err_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.has_byte     = has_q;
  assign out_o.frame_byte   = fb_q;
  assign out_o.frame_number = fn_q;
  assign out_o.frame_end    = fe_q;
  assign out_o.error_code   = err_q;

  a_nz_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nz_q <= CW'(MAX_FRAMES))
    else $error("stored frame count above table size");

  a_pay_left: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_PAY && !drop_q) |-> (left_q != '0 && cur_k_q < nz_q))
    else $error("payload phase without a live frame");

  a_end_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_i.packet_end) |=> (phase_q == PH_LEN_HI && !drop_q))
    else $error("packet end did not return to length phase");

  a_no_loss: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_o.ready) |-> !in_i.ready)
    else $error("input taken while output word is held");

endmodule
